/* rtl/core/tbsa_pkg.sv */
package tbsa_pkg;

  // result status codes
  localparam logic [1:0] ST_GRANT = 2'd0;
  localparam logic [1:0] ST_EXHAUST = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  localparam logic [4:0] BLOCKS_EN_RESET = 5'd16;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FREE  = 7'b0000100,
    S_BLK   = 7'b0001000,
    S_ROW   = 7'b0010000,
    S_PICK  = 7'b0100000,
    S_RESP  = 7'b1000000
  } tbsa_state_t;

  typedef struct packed {
    logic sweep;
    logic start_free;
    logic start_alloc;
    logic rf_read;
    logic row_phase;
    logic pick_phase;
    logic free_commit;
    logic exhaust;
    logic blk_next;
    logic resp_load;
  } tbsa_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic alloc_none;
    logic row_hit;
    logic col_hit;
    logic last_blk;
    logic out_free;
  } tbsa_stat_t;

endpackage

/* rtl/core/tbsa_ram.sv */
module tbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/tbsa_ctrl.sv */
module tbsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_kind,
  output logic                in_tready,
  input  tbsa_pkg::tbsa_stat_t stat,
  output tbsa_pkg::tbsa_cmd_t  cmd
);
  import tbsa_pkg::*;

  tbsa_state_t state_r, state_nxt;
  logic accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_FREE) begin
            cmd.start_free = 1'b1;
            state_nxt = S_FREE;
          end else begin
            cmd.start_alloc = 1'b1;
            if (stat.alloc_none) begin
              cmd.exhaust = 1'b1;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_BLK;
            end
          end
        end
      end
      S_FREE: begin
        cmd.free_commit = 1'b1;
        state_nxt = S_RESP;
      end
      S_BLK: begin
        cmd.rf_read = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.row_phase = 1'b1;
        if (stat.row_hit) begin
          state_nxt = S_PICK;
        end else if (stat.last_blk) begin
          cmd.exhaust = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.blk_next = 1'b1;
          state_nxt = S_BLK;
        end
      end
      S_PICK: begin
        cmd.pick_phase = 1'b1;
        if (stat.col_hit) begin
          state_nxt = S_RESP;
        end else if (stat.last_blk) begin
          cmd.exhaust = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.blk_next = 1'b1;
          state_nxt = S_BLK;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("ready held after accept");
  a_load_only_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && stat.out_free |=> in_tready)
    else $error("response did not return to idle");
  a_exhaust_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exhaust && cmd.pick_phase |-> !stat.col_hit)
    else $error("exhausted with a free column");

endmodule

/* rtl/core/tbsa_dp.sv */
module tbsa_dp #(
  parameter int NUM_BLOCKS = 16,
  parameter int AXIS_LEN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  input  logic [15:0]         in_tdata,
  input  tbsa_pkg::tbsa_cmd_t  cmd,
  output tbsa_pkg::tbsa_stat_t stat,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [15:0]         out_tdata,
  output logic [1:0]          out_tuser
);
  import tbsa_pkg::*;

  localparam int ROWS = AXIS_LEN - 1;
  localparam int SLOT_DEPTH = NUM_BLOCKS * ROWS;
  localparam int SAW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = ($clog2(NUM_BLOCKS + 1) > 5) ? $clog2(NUM_BLOCKS + 1) : 5;
  localparam logic [AXIS_LEN-1:0] FULL = {{(AXIS_LEN-1){1'b1}}, 1'b0};

  function automatic logic [5:0] first_clear(input logic [AXIS_LEN-1:0] w);
    logic [5:0] p;
    p = '0;
    for (int i = AXIS_LEN - 1; i >= 1; i--) begin
      if (!w[i]) p = 6'(i);
    end
    return p;
  endfunction

  logic [4:0]    blocks_en_r;
  logic [SAW-1:0] sweep_cnt_r;
  logic [BW-1:0] blk_r;
  logic [5:0]    row_r, col_r;
  logic [SAW-1:0] slot_addr_r;
  logic [BW-1:0] free_blk_r;
  logic          free_ok_r;
  logic [1:0]    res_status_r;
  logic [3:0]    res_blk_r;
  logic [5:0]    res_row_r, res_col_r;
  logic          out_valid_r;
  logic [15:0]   out_data_r;
  logic [1:0]    out_user_r;

  logic [3:0] in_blk;
  logic [5:0] in_row, in_col;
  assign in_blk = in_tdata[3:0];
  assign in_row = in_tdata[9:4];
  assign in_col = in_tdata[15:10];

  logic [CW-1:0] limit, blk_plus;
  assign limit = (CW'(blocks_en_r) > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(blocks_en_r);
  assign blk_plus = CW'(blk_r) + CW'(1);

  logic [AXIS_LEN-1:0] slot_rdata, rf_rdata, enc_word;
  logic [5:0] enc;
  assign enc_word = cmd.pick_phase ? slot_rdata : rf_rdata;
  assign enc = first_clear(enc_word);

  logic row_hit, col_hit, in_ok;
  assign row_hit = (enc != 6'd0);
  assign col_hit = (enc != 6'd0);
  assign in_ok = (32'(in_blk) < NUM_BLOCKS) && (in_row != 6'd0) && (32'(in_row) < AXIS_LEN)
    && (in_col != 6'd0) && (32'(in_col) < AXIS_LEN);

  logic [AXIS_LEN-1:0] col_set, row_set, free_cbit, free_rbit, rf_set;
  assign col_set = slot_rdata | (AXIS_LEN'(1) << enc);
  assign row_set = AXIS_LEN'(1) << row_r;
  assign rf_set = rf_rdata | row_set;
  assign free_cbit = AXIS_LEN'(1) << col_r;
  assign free_rbit = AXIS_LEN'(1) << row_r;

  logic grant;
  assign grant = cmd.pick_phase && col_hit;

  // slot bitmap RAM
  logic           s_we, s_re;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [AXIS_LEN-1:0] s_wdata;
  // row-full RAM
  logic          r_we, r_re;
  logic [BW-1:0] r_waddr, r_raddr;
  logic [AXIS_LEN-1:0] r_wdata;

  always_comb begin
    s_we = 1'b0;
    s_waddr = slot_addr_r;
    s_wdata = '0;
    r_we = 1'b0;
    r_waddr = blk_r;
    r_wdata = '0;
    if (cmd.sweep) begin
      s_we = 1'b1;
      s_waddr = sweep_cnt_r;
      r_we = (32'(sweep_cnt_r) < NUM_BLOCKS);
      r_waddr = sweep_cnt_r[BW-1:0];
    end else if (grant) begin
      s_we = 1'b1;
      s_wdata = col_set;
      r_we = ((col_set & FULL) == FULL);
      r_wdata = rf_set;
    end else if (cmd.free_commit && free_ok_r) begin
      s_we = 1'b1;
      s_wdata = slot_rdata & ~free_cbit;
      r_we = 1'b1;
      r_waddr = free_blk_r;
      r_wdata = rf_rdata & ~free_rbit;
    end
  end

  assign s_re = cmd.start_free || (cmd.row_phase && row_hit);
  assign s_raddr = cmd.start_free
    ? SAW'(SAW'(BW'(in_blk)) * SAW'(ROWS) + SAW'(in_row) - SAW'(1))
    : SAW'(SAW'(blk_r) * SAW'(ROWS) + SAW'(enc) - SAW'(1));
  assign r_re = cmd.start_free || cmd.rf_read;
  assign r_raddr = cmd.start_free ? BW'(in_blk) : blk_r;

  tbsa_ram #(.WIDTH(AXIS_LEN), .DEPTH(SLOT_DEPTH)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(slot_rdata)
  );

  tbsa_ram #(.WIDTH(AXIS_LEN), .DEPTH(NUM_BLOCKS)) u_rf_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .re(r_re), .raddr(r_raddr), .rdata(rf_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_en_r <= BLOCKS_EN_RESET;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) blocks_en_r <= cfg_wdata;
      if (cmd.sweep) sweep_cnt_r <= sweep_cnt_r + SAW'(1);
      if (cmd.resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_free) begin
      free_blk_r <= BW'(in_blk);
      row_r <= in_row;
      col_r <= in_col;
      free_ok_r <= in_ok;
      slot_addr_r <= s_raddr;
    end
    if (cmd.start_alloc) blk_r <= '0;
    if (cmd.blk_next) blk_r <= blk_r + BW'(1);
    if (cmd.row_phase && row_hit) begin
      row_r <= enc;
      slot_addr_r <= s_raddr;
    end
    if (cmd.free_commit) begin
      res_status_r <= ST_FREED;
      res_blk_r <= '0;
      res_row_r <= '0;
      res_col_r <= '0;
    end
    if (cmd.exhaust) begin
      res_status_r <= ST_EXHAUST;
      res_blk_r <= '0;
      res_row_r <= '0;
      res_col_r <= '0;
    end
    if (grant) begin
      res_status_r <= ST_GRANT;
      res_blk_r <= 4'(blk_r);
      res_row_r <= row_r;
      res_col_r <= enc;
    end
    if (cmd.resp_load) begin
      out_user_r <= res_status_r;
      out_data_r <= {res_col_r, res_row_r, res_blk_r};
    end
  end

  assign stat.sweep_done = (32'(sweep_cnt_r) == SLOT_DEPTH - 1);
  assign stat.alloc_none = (limit == '0);
  assign stat.row_hit = row_hit;
  assign stat.col_hit = col_hit;
  assign stat.last_blk = (blk_plus >= limit);
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

/* rtl/core/two_level_bitmap_slot_allocator.sv */
// channel | dir | handshake         | tdata                        | tuser
// in      | in  | in_tvalid/tready  | free_block, free_row, free_col | kind
// out     | out | out_tvalid/tready | got_block, got_row, got_col  | status
// cfg     | in  | cfg_we            | blocks_enabled (cfg_wdata)   | -
// A free reads both RAMs, then writes back and loads the result. An alloc steps
// through blocks: row-full read, row search with slot-row read, column pick with
// write-back (skipped for a block whose rows are all full), on RAMs with one write
// and one read port. After reset a clearing pass over all NUM_BLOCKS*(AXIS_LEN-1)
// slot words (1008 by default) runs with in_tready low. A stalled result holds
// only the final state; the next beat is taken once the result register frees up.
module two_level_bitmap_slot_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int AXIS_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // free_block[3:0], free_row[9:4], free_col[15:10]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // got_block[3:0], got_row[9:4], got_col[15:10]
  output logic [1:0]  out_tuser   // status
);
  import tbsa_pkg::*;

  tbsa_cmd_t  cmd;
  tbsa_stat_t stat;

  tbsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_kind(in_tuser),
    .in_tready(in_tready), .stat(stat), .cmd(cmd)
  );

  tbsa_dp #(.NUM_BLOCKS(NUM_BLOCKS), .AXIS_LEN(AXIS_LEN)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tdata(in_tdata), .cmd(cmd), .stat(stat), .out_tready(out_tready),
    .out_tvalid(out_tvalid), .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  a_grant_not_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_GRANT) |-> (out_tdata[9:4] != 6'd0)
      && (out_tdata[15:10] != 6'd0))
    else $error("granted a reserved index");
  a_nongrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_GRANT) |-> (out_tdata == 16'd0))
    else $error("slot fields set on non-grant");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_GRANT) || (out_tuser == ST_EXHAUST)
      || (out_tuser == ST_FREED))
    else $error("bad status code");

endmodule
